/* rtl/core/nfc_tlv_stream_parser_defines.svh */
// Assertion macros used by the TLV stream parser top level.
`ifndef NFC_TLV_STREAM_PARSER_DEFINES_SVH
`define NFC_TLV_STREAM_PARSER_DEFINES_SVH

// The expression must never hold at a clock edge outside reset.
`define NFC_TLV_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("nfc_tlv: forbidden condition seen");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define NFC_TLV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("nfc_tlv: implication failed");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define NFC_TLV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("nfc_tlv: next-cycle implication failed");

`endif

/* rtl/core/nfctlv_pkg.sv */
// Types and constants shared by the TLV stream parser modules.
package nfctlv_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TYPE_W     = 8;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned OUT_POS_W  = 20;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned TDATA_W    = 64;

  localparam logic [BYTE_W-1:0] LONG_LEN_MARK   = 8'hFF;
  localparam logic [BYTE_W-1:0] NULL_RESET      = 8'h00;
  localparam logic [BYTE_W-1:0] TERMINATOR_RESET = 8'hFE;

  localparam logic [CFG_IDX_W-1:0] CFG_NULL_CODE       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR_CODE = 1'b1;

  typedef enum logic [1:0] {
    KIND_BLOCK    = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_BROKEN   = 2'd2
  } result_kind_e;

  typedef struct packed {
    result_kind_e           kind;
    logic [TYPE_W-1:0]      block_type;
    logic [OUT_POS_W-1:0]   value_offset;
    logic [LEN_W-1:0]       value_length;
    logic [OUT_POS_W-1:0]   sequence_size;
  } result_t;

  // Results caused by one byte: up to two, the first in front.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_t;

  typedef struct packed {
    logic [1:0] count;
    logic       can_load;
  } rq_status_t;

endpackage

/* rtl/core/nfctlv_parse_core.sv */
// Per-byte TLV parse state, configuration registers and result generation.
module nfctlv_parse_core #(
  parameter int unsigned POSITION_BITS = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [nfctlv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nfctlv_pkg::BYTE_W-1:0]     cfg_data_i,
  input  logic                              fire_i,
  input  logic [nfctlv_pkg::BYTE_W-1:0]     data_i,
  input  logic                              last_i,
  output nfctlv_pkg::step_t                 step_o
);
  import nfctlv_pkg::*;

  typedef enum logic [6:0] {
    PH_TYPE   = 7'b0000001,
    PH_LEN    = 7'b0000010,
    PH_LENHI  = 7'b0000100,
    PH_LENLO  = 7'b0001000,
    PH_VALUE  = 7'b0010000,
    PH_DONE   = 7'b0100000,
    PH_BROKEN = 7'b1000000
  } phase_e;

  localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);

  logic [BYTE_W-1:0]        null_q, term_q;
  phase_e                   phase_q, phase_d, ph;
  logic [TYPE_W-1:0]        type_q, type_d;
  logic [LEN_W-1:0]         len_q, len_d;
  logic [LEN_W-1:0]         rem_q, rem_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] vstart_q, vstart_d;
  logic                     at_max, start, blk, term, brk;
  result_t                  blk_res, term_res, brk_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      null_q <= NULL_RESET;
      term_q <= TERMINATOR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NULL_CODE:       null_q <= cfg_data_i;
        CFG_TERMINATOR_CODE: term_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    ph       = phase_q;
    type_d   = type_q;
    len_d    = len_q;
    rem_d    = rem_q;
    vstart_d = vstart_q;
    start    = 1'b0;
    blk      = 1'b0;
    term     = 1'b0;
    brk      = 1'b0;
    at_max   = (pos_q == PosMax);

    // At the position limit the rest of the buffer cannot be parsed.
    if (phase_q != PH_DONE && at_max) begin
      ph = PH_BROKEN;
    end
    phase_d = ph;

    unique case (ph) inside
      PH_TYPE: begin
        if (data_i == null_q) begin
          phase_d = PH_TYPE;
        end else if (data_i == term_q) begin
          term    = 1'b1;
          phase_d = PH_DONE;
        end else begin
          type_d  = data_i;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        if (data_i == LONG_LEN_MARK) begin
          phase_d = PH_LENHI;
        end else begin
          len_d = {{(LEN_W-BYTE_W){1'b0}}, data_i};
          start = 1'b1;
        end
      end
      PH_LENHI: begin
        len_d   = {data_i, {BYTE_W{1'b0}}};
        phase_d = PH_LENLO;
      end
      PH_LENLO: begin
        len_d = {len_q[LEN_W-1:BYTE_W], data_i};
        start = 1'b1;
      end
      PH_VALUE: begin
        rem_d = rem_q - LEN_W'(1);
        if (rem_d == '0) begin
          blk     = 1'b1;
          phase_d = PH_TYPE;
        end
      end
      PH_DONE, PH_BROKEN: begin
        phase_d = ph;
      end
      default: begin
        phase_d = ph;
      end
    endcase

    // Length field complete: an empty value is reported at once.
    if (start) begin
      vstart_d = pos_q + PosOne;
      if (len_d == '0) begin
        blk     = 1'b1;
        phase_d = PH_TYPE;
      end else begin
        rem_d   = len_d;
        phase_d = PH_VALUE;
      end
    end

    pos_d = at_max ? pos_q : pos_q + PosOne;

    blk_res.kind          = KIND_BLOCK;
    blk_res.block_type    = type_q;
    blk_res.value_offset  = OUT_POS_W'(vstart_d);
    blk_res.value_length  = len_d;
    blk_res.sequence_size = '0;

    term_res.kind          = KIND_COMPLETE;
    term_res.block_type    = '0;
    term_res.value_offset  = '0;
    term_res.value_length  = '0;
    term_res.sequence_size = OUT_POS_W'(pos_q + PosOne);

    brk_res.kind          = KIND_BROKEN;
    brk_res.block_type    = '0;
    brk_res.value_offset  = '0;
    brk_res.value_length  = '0;
    brk_res.sequence_size = '0;

    // End of buffer: report a missing terminator and start afresh.
    if (last_i) begin
      brk      = (phase_d != PH_DONE);
      phase_d  = PH_TYPE;
      type_d   = '0;
      len_d    = '0;
      rem_d    = '0;
      pos_d    = '0;
      vstart_d = '0;
    end

    step_o.count  = {1'b0, blk | term} + {1'b0, brk};
    step_o.first  = blk ? blk_res : (term ? term_res : brk_res);
    step_o.second = brk_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TYPE;
      type_q   <= '0;
      len_q    <= '0;
      rem_q    <= '0;
      pos_q    <= '0;
      vstart_q <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
      pos_q    <= pos_d;
      vstart_q <= vstart_d;
    end
  end

endmodule

/* rtl/core/nfctlv_result_queue.sv */
// Two-entry result register that presents the results of one byte in turn.
module nfctlv_result_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  nfctlv_pkg::step_t     step_i,
  input  logic                  ready_i,
  output logic                  valid_o,
  output logic                  last_o,
  output nfctlv_pkg::result_t   head_o,
  output nfctlv_pkg::rq_status_t status_o
);
  import nfctlv_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  result_t    slot0_q, slot0_d, slot1_q, slot1_d;
  logic       pop;

  assign pop     = (cnt_q != 2'd0) && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign last_o  = (cnt_q == 2'd1);
  assign head_o  = slot0_q;

  assign status_o.count    = cnt_q;
  assign status_o.can_load = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (load_i) begin
      cnt_d   = step_i.count;
      slot0_d = step_i.first;
      slot1_d = step_i.second;
    end else if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

/* rtl/core/nfc_tlv_stream_parser.sv */
// Top level of the TLV stream parser: input register, parse core, result queue.
//
// Bytes of a tag memory buffer enter on the slave stream, one per transaction,
// with tlast marking the final byte of the buffer. Each transaction lands in an
// input register; from there the parse core advances its state and loads the
// results of that byte into a two-entry result register.
// Results leave on the master stream: tuser carries the result kind, tlast
// marks the last result caused by one input byte, and tdata the block fields.
// A byte that causes no result produces no output transaction.
//
// The first result of an input byte is presented once the byte has passed
// through the input register and then the result register.
// Throughput is one byte per cycle while the result register can take each
// byte's results; a byte with two results (a block completed by the final byte,
// then the broken report) keeps the next byte waiting in the input register.
//
// When the receiver stalls, results hold in the result register and the
// input register keeps one more byte before tready falls. Reset clears the
// parse state and restores the padding and terminator codes to their defaults;
// after every final byte the parse state returns to its reset values too.
`include "nfc_tlv_stream_parser_defines.svh"

module nfc_tlv_stream_parser #(
  parameter int unsigned POSITION_BITS = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [nfctlv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nfctlv_pkg::BYTE_W-1:0]     cfg_data_i,
  // Slave stream: tdata = data_byte[7:0]; tlast = final_byte
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [nfctlv_pkg::BYTE_W-1:0]     s_axis_tdata_i,
  input  logic                              s_axis_tlast_i,
  // Master stream: tdata = block_type[7:0], value_offset[27:8],
  // value_length[43:28], sequence_size[63:44]; tuser = result_kind[1:0];
  // tlast = run_end
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [nfctlv_pkg::TDATA_W-1:0]    m_axis_tdata_o,
  output logic [1:0]                        m_axis_tuser_o,
  output logic                              m_axis_tlast_o
);
  import nfctlv_pkg::*;

  logic              in_valid_q;
  logic [BYTE_W-1:0] in_data_q;
  logic              in_last_q;
  logic              fire;
  step_t             step;
  result_t           head;
  rq_status_t        rq_status;

  // A held byte moves on once the result register can take its results.
  assign fire            = in_valid_q && rq_status.can_load;
  assign s_axis_tready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  nfctlv_parse_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .data_i     (in_data_q),
    .last_i     (in_last_q),
    .step_o     (step)
  );

  nfctlv_result_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire),
    .step_i   (step),
    .ready_i  (m_axis_tready_i),
    .valid_o  (m_axis_tvalid_o),
    .last_o   (m_axis_tlast_o),
    .head_o   (head),
    .status_o (rq_status)
  );

  assign m_axis_tdata_o = {head.sequence_size, head.value_length,
                           head.value_offset, head.block_type};
  assign m_axis_tuser_o = head.kind;

  // A byte that cannot move on must stay put in the input register.
  `NFC_TLV_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_q && !fire,
                       in_valid_q && $stable(in_data_q) && $stable(in_last_q))
  // With two results queued the head is never the last of its byte.
  `NFC_TLV_ASSERT_IMP(a_pair_not_last, clk_i, rst_ni, rq_status.count == 2'd2,
                      !m_axis_tlast_o)
  // Terminator and broken reports always close the results of their byte.
  `NFC_TLV_ASSERT_IMP(a_report_last, clk_i, rst_ni,
                      m_axis_tvalid_o && (m_axis_tuser_o != KIND_BLOCK),
                      m_axis_tlast_o)
  // The result kind never goes beyond the broken report code.
  `NFC_TLV_ASSERT_NEVER(a_kind_code, clk_i, rst_ni,
                        m_axis_tvalid_o && (m_axis_tuser_o > KIND_BROKEN))

endmodule
